FILE: src/dcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcb_pkg
// Types and constants shared by the DC-blocking highpass block and its
// stream interfaces.
// ----------------------------------------------------------------------------
package dcb_pkg;

	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 16;
	localparam int VALUE_W  = 18;
	localparam int MASK_W   = 8;
	localparam int COEF_W   = 16;
	localparam int DATA_W   = 16;

	typedef logic [CH_W-1:0]            channel_t;
	typedef logic [SAMPLE_W-1:0]        sample_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic [MASK_W-1:0]          mask_t;
	typedef logic [COEF_W-1:0]          coef_t;
	typedef logic [DATA_W-1:0]          cfg_data_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_ENABLE_MASK = 1'b0,
		REG_COEFFICIENT = 1'b1
	} reg_index_t;

	localparam mask_t MASK_RESET = 8'h00;
	localparam coef_t COEF_RESET = 16'd65350;

	localparam value_t VALUE_MAX = 18'sh1FFFF;
	localparam value_t VALUE_MIN = 18'sh20000;

endpackage

FILE: src/dcb_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcb_sample_if
// Input stream: one converter sample and its channel number per item.
// ----------------------------------------------------------------------------
interface dcb_sample_if;

	logic               valid;
	logic               ready;
	dcb_pkg::channel_t  channel;
	dcb_pkg::sample_t   sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);

endinterface

FILE: src/dcb_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcb_result_if
// Result stream: echoed channel, filtered or raw value and a filtered flag.
// ----------------------------------------------------------------------------
interface dcb_result_if;

	logic               valid;
	logic               ready;
	dcb_pkg::channel_t  out_channel;
	dcb_pkg::value_t    value;
	logic               filtered;

	modport source (output valid, output out_channel, output value, output filtered,
		input ready);
	modport sink   (input valid, input out_channel, input value, input filtered,
		output ready);

endinterface

FILE: src/multichannel_dc_block_highpass_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_dc_block_highpass_unit
// A sample passes the compute stage, then the result stage. Throughput: 1 item
// per cycle while results are taken; the per-channel state is read and written
// in the single compute stage, so items on the same channel follow back to back.
// Reset: arst_n clears both stages, zeroes all channel state, loads the
// enable mask with 0 and the coefficient with 65350.
// ----------------------------------------------------------------------------
module multichannel_dc_block_highpass_unit #(
	parameter int CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dcb_sample_if.sink            sample_port,
	dcb_result_if.source          result_port,
	input  logic                  write_enable,
	input  dcb_pkg::reg_index_t   reg_index,
	input  dcb_pkg::cfg_data_t    write_data
);

	import dcb_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	// Configuration registers
	mask_t  mask_q;
	coef_t  coef_q;

	// Per-channel filter state
	sample_t prev_in_q  [CHANNELS];
	value_t  prev_out_q [CHANNELS];

	// Compute stage
	logic     valid_s1;
	channel_t ch_s1;
	sample_t  sample_s1;

	// Result stage
	logic     valid_s2;
	channel_t ch_s2;
	value_t   value_s2;
	logic     filtered_s2;

	logic adv_s2;
	logic adv_s1;

	idx_t                idx_s1;
	logic                en_s1;
	value_t              y_prev;
	sample_t             x_prev;
	logic signed [18:0]  diff_sum;
	logic signed [35:0]  product;
	logic signed [19:0]  y_full;
	value_t              y_sat;
	value_t              y_dbl;
	value_t              result_value;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
			coef_q <= COEF_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_ENABLE_MASK: mask_q <= write_data[MASK_W-1:0];
				REG_COEFFICIENT: mask_q <= mask_q;
				default:         mask_q <= mask_q;
			endcase
			unique case (reg_index)
				REG_COEFFICIENT: coef_q <= write_data[COEF_W-1:0];
				REG_ENABLE_MASK: coef_q <= coef_q;
				default:         coef_q <= coef_q;
			endcase
		end
	end

	// Handshake: the result stage frees when taken, the compute stage when it moves on
	assign adv_s2            = !valid_s2 || result_port.ready;
	assign adv_s1            = valid_s1 && adv_s2;
	assign sample_port.ready = !valid_s1 || adv_s2;

	// Capture an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_port.ready) begin
			valid_s1 <= sample_port.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_port.valid && sample_port.ready) begin
			ch_s1     <= sample_port.channel;
			sample_s1 <= sample_port.sample;
		end
	end

	// Select the channel state and decide whether the filter applies
	assign idx_s1 = IDX_W'(ch_s1);
	assign en_s1  = (32'(ch_s1) < CHANNELS) && mask_q[ch_s1];
	assign y_prev = en_s1 ? prev_out_q[idx_s1] : '0;
	assign x_prev = en_s1 ? prev_in_q[idx_s1]  : '0;

	// y = floor(a * (y_prev + x - x_prev) / 65536), saturated, then doubled
	always_comb begin
		diff_sum = 19'(y_prev) + $signed({3'b000, sample_s1})
			- $signed({3'b000, x_prev});
		product  = $signed({1'b0, coef_q}) * diff_sum;
		y_full   = product[35:16];
		if (y_full > 20'(VALUE_MAX)) begin
			y_sat = VALUE_MAX;
		end else if (y_full < 20'(VALUE_MIN)) begin
			y_sat = VALUE_MIN;
		end else begin
			y_sat = y_full[VALUE_W-1:0];
		end
		if (y_sat[VALUE_W-1] != y_sat[VALUE_W-2]) begin
			y_dbl = y_sat[VALUE_W-1] ? VALUE_MIN : VALUE_MAX;
		end else begin
			y_dbl = {y_sat[VALUE_W-2:0], 1'b0};
		end
		result_value = en_s1 ? y_dbl : $signed({2'b00, sample_s1});
	end

	// Update channel state once, as the item leaves the compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				prev_in_q[i]  <= '0;
				prev_out_q[i] <= '0;
			end
		end else if (adv_s1 && en_s1) begin
			prev_in_q[idx_s1]  <= sample_s1;
			prev_out_q[idx_s1] <= y_sat;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ch_s2       <= ch_s1;
			value_s2    <= result_value;
			filtered_s2 <= en_s1;
		end
	end

	assign result_port.valid       = valid_s2;
	assign result_port.out_channel = ch_s2;
	assign result_port.value       = value_s2;
	assign result_port.filtered    = filtered_s2;

`ifndef ASSERT_OFF
	// A filtered item leaves its sample as the channel's previous input
	a_state_written: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && en_s1) |=> (prev_in_q[$past(idx_s1)] == $past(sample_s1)))
		else $error("channel state not updated by filtered item");

	// A raw pass-through result is a non-negative 16-bit sample
	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_port.valid && !result_port.filtered) |-> (result_port.value[17:16] == 2'b00))
		else $error("raw result outside sample range");

	// Input stalls only when both stages are full and the result is not taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_port.ready |-> (valid_s1 && result_port.valid && !result_port.ready))
		else $error("input stalled without a full pipeline");
`endif

endmodule
